// ----- rtl/core/fccw_pkg.sv -----
// Shared types, codes and constants for the FAT12 cluster chain walker.
package fccw_pkg;

    localparam int FAT_BYTES_DEF   = 8192;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int DIR_ENTRY_BYTES = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int FAT_ADDR_W  = 13;
    localparam int CLUSTER_W   = 12;
    localparam int SIZE_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_ADDR_W = 14;

    localparam int ROOT_NUM_W = 16 + $clog2(DIR_ENTRY_BYTES);

    localparam logic [CLUSTER_W-1:0] END_MARK           = 12'hFF8;
    localparam logic [SIZE_W-1:0]    FIRST_DATA_CLUSTER = 32'd2;

    localparam logic [15:0] RST_SECTOR_BYTES    = 16'd512;
    localparam logic [7:0]  RST_CLUSTER_SECTORS = 8'd1;
    localparam logic [15:0] RST_RESERVED_COUNT  = 16'd1;
    localparam logic [7:0]  RST_FAT_COPIES      = 8'd2;
    localparam logic [15:0] RST_FAT_SECTORS     = 16'd9;
    localparam logic [15:0] RST_ROOT_ENTRIES    = 16'd224;
    localparam logic [31:0] RST_MAX_FILE_BYTES  = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SECTOR_BYTES    = 3'd0,
        REG_CLUSTER_SECTORS = 3'd1,
        REG_RESERVED_COUNT  = 3'd2,
        REG_FAT_COPIES      = 3'd3,
        REG_FAT_SECTORS     = 3'd4,
        REG_ROOT_ENTRIES    = 3'd5,
        REG_MAX_FILE_BYTES  = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_FAT_WRITE = 2'd0,
        KIND_START     = 2'd1,
        KIND_ADVANCE   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_FAT_WRITE = 2'd0,
        OP_START     = 2'd1,
        OP_REJECT    = 2'd2,
        OP_ADVANCE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CHUNK       = 3'd0,
        ST_ACCEPTED    = 3'd1,
        ST_TOO_LARGE   = 3'd2,
        ST_ENDED_EARLY = 3'd3,
        ST_NO_FILE     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        GEO_LOAD  = 2'd0,
        GEO_DIV   = 2'd1,
        GEO_SUM   = 2'd2,
        GEO_READY = 2'd3
    } geo_state_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_ADV1 = 3'd1,
        BK_ADV2 = 3'd2,
        BK_EMIT = 3'd3,
        BK_WARN = 3'd4
    } back_state_t;

    typedef struct packed {
        op_t                   op;
        logic [FAT_ADDR_W-1:0] fat_addr;
        logic [7:0]            fat_byte;
        logic [CLUSTER_W-1:0]  start_cluster;
        logic [SIZE_W-1:0]     file_size;
    } q_entry_t;

    typedef struct packed {
        logic        ready;
        logic [31:0] data_start;
        logic [15:0] sector_bytes;
        logic [7:0]  cluster_sectors;
        logic [23:0] csize;
        logic [31:0] max_file_bytes;
    } geo_t;

endpackage

// ----- rtl/core/fccw_geometry.sv -----
// Volume geometry registers and the data start / cluster size calculation.
module fccw_geometry (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [fccw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fccw_pkg::CFG_DATA_W-1:0] cfg_data,
    output fccw_pkg::geo_t                 geo
);

    localparam int NW = fccw_pkg::ROOT_NUM_W;
    localparam int SW = $clog2(NW);

    logic [15:0] sb_reg;
    logic [7:0]  cs_reg;
    logic [15:0] rsv_reg;
    logic [7:0]  copies_reg;
    logic [15:0] fsec_reg;
    logic [15:0] rent_reg;
    logic [31:0] max_reg;

    fccw_pkg::geo_state_t state_reg, state_next;

    logic load_en, step_en, sum_en, ready;

    logic [NW-1:0] quo_reg, quo_next;
    logic [16:0]   rem_reg, rem_next;
    logic [SW-1:0] step_reg;
    logic [23:0]   fat_area_reg;
    logic [23:0]   csize_reg;
    logic [31:0]   data_start_reg;

    logic [16:0]   trial;
    logic          trial_ge;
    logic [31:0]   root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_reg     <= fccw_pkg::RST_SECTOR_BYTES;
            cs_reg     <= fccw_pkg::RST_CLUSTER_SECTORS;
            rsv_reg    <= fccw_pkg::RST_RESERVED_COUNT;
            copies_reg <= fccw_pkg::RST_FAT_COPIES;
            fsec_reg   <= fccw_pkg::RST_FAT_SECTORS;
            rent_reg   <= fccw_pkg::RST_ROOT_ENTRIES;
            max_reg    <= fccw_pkg::RST_MAX_FILE_BYTES;
        end
        else if (cfg_wr_en)
        begin
            unique case (fccw_pkg::cfg_reg_t'(cfg_index))
                fccw_pkg::REG_SECTOR_BYTES:    sb_reg     <= cfg_data[15:0];
                fccw_pkg::REG_CLUSTER_SECTORS: cs_reg     <= cfg_data[7:0];
                fccw_pkg::REG_RESERVED_COUNT:  rsv_reg    <= cfg_data[15:0];
                fccw_pkg::REG_FAT_COPIES:      copies_reg <= cfg_data[7:0];
                fccw_pkg::REG_FAT_SECTORS:     fsec_reg   <= cfg_data[15:0];
                fccw_pkg::REG_ROOT_ENTRIES:    rent_reg   <= cfg_data[15:0];
                fccw_pkg::REG_MAX_FILE_BYTES:  max_reg    <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fccw_pkg::GEO_LOAD:  state_next = fccw_pkg::GEO_DIV;
            fccw_pkg::GEO_DIV:
            begin
                if (step_reg == SW'(NW - 1))
                begin
                    state_next = fccw_pkg::GEO_SUM;
                end
            end
            fccw_pkg::GEO_SUM:   state_next = fccw_pkg::GEO_READY;
            fccw_pkg::GEO_READY: state_next = fccw_pkg::GEO_READY;
            default:             state_next = fccw_pkg::GEO_LOAD;
        endcase
        if (cfg_wr_en)
        begin
            state_next = fccw_pkg::GEO_LOAD;
        end
    end

    always_comb
    begin
        load_en = 1'b0;
        step_en = 1'b0;
        sum_en  = 1'b0;
        ready   = 1'b0;
        unique case (state_reg)
            fccw_pkg::GEO_LOAD:  load_en = 1'b1;
            fccw_pkg::GEO_DIV:   step_en = 1'b1;
            fccw_pkg::GEO_SUM:   sum_en  = 1'b1;
            fccw_pkg::GEO_READY: ready   = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fccw_pkg::GEO_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // restoring divide, one quotient bit per cycle
    assign trial    = {rem_reg[15:0], quo_reg[NW-1]};
    assign trial_ge = trial >= {1'b0, sb_reg};

    always_comb
    begin
        rem_next = trial_ge ? (trial - {1'b0, sb_reg}) : trial;
        quo_next = {quo_reg[NW-2:0], trial_ge};
    end

    // ceiling: bump the quotient when anything is left over
    assign root = (sb_reg == 16'd0) ? 32'd0
                : (32'(quo_reg) + ((rem_reg != 17'd0) ? 32'd1 : 32'd0));

    always_ff @(posedge clk)
    begin
        fat_area_reg <= 24'(copies_reg) * 24'(fsec_reg);
        csize_reg    <= 24'(cs_reg) * 24'(sb_reg);
        if (load_en)
        begin
            quo_reg  <= NW'(rent_reg) * NW'(fccw_pkg::DIR_ENTRY_BYTES);
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (step_en)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg + 1'b1;
        end
        if (sum_en)
        begin
            data_start_reg <= 32'(rsv_reg) + 32'(fat_area_reg) + root;
        end
    end

    always_comb
    begin
        geo.ready           = ready;
        geo.data_start      = data_start_reg;
        geo.sector_bytes    = sb_reg;
        geo.cluster_sectors = cs_reg;
        geo.csize           = csize_reg;
        geo.max_file_bytes  = max_reg;
    end

endmodule

// ----- rtl/core/fccw_front.sv -----
// Front end: takes input requests, classifies them and feeds the queue.
module fccw_front #(
    parameter int FAT_BYTES = fccw_pkg::FAT_BYTES_DEF
) (
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic [fccw_pkg::FAT_ADDR_W-1:0] fat_addr,
    input  logic [7:0]                      fat_byte,
    input  logic [fccw_pkg::CLUSTER_W-1:0]  start_cluster,
    input  logic [fccw_pkg::SIZE_W-1:0]     file_size,
    input  logic [31:0]                     max_file_bytes,
    input  logic                            q_full,
    output logic                            push,
    output fccw_pkg::q_entry_t              push_entry
);

    logic keep;
    fccw_pkg::op_t op;

    always_comb
    begin
        keep = 1'b1;
        op   = fccw_pkg::OP_ADVANCE;
        unique case (fccw_pkg::kind_t'(kind))
            fccw_pkg::KIND_FAT_WRITE:
            begin
                op   = fccw_pkg::OP_FAT_WRITE;
                keep = 32'(fat_addr) < 32'(FAT_BYTES);
            end
            fccw_pkg::KIND_START:
            begin
                op = (file_size > max_file_bytes) ? fccw_pkg::OP_REJECT
                                                  : fccw_pkg::OP_START;
            end
            fccw_pkg::KIND_ADVANCE:
            begin
                op = fccw_pkg::OP_ADVANCE;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full && keep;

    always_comb
    begin
        push_entry.op            = op;
        push_entry.fat_addr      = fat_addr;
        push_entry.fat_byte      = fat_byte;
        push_entry.start_cluster = start_cluster;
        push_entry.file_size     = file_size;
    end

endmodule

// ----- rtl/core/fccw_queue.sv -----
// Small FIFO of classified requests between front and back end.
module fccw_queue #(
    parameter int DEPTH = fccw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fccw_pkg::q_entry_t push_entry,
    input  logic               pop,
    output logic               q_valid,
    output fccw_pkg::q_entry_t q_head,
    output logic               q_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fccw_pkg::q_entry_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    logic do_pop;

    assign do_pop  = pop && (count_reg != '0);
    assign q_valid = count_reg != '0;
    assign q_full  = count_reg == CW'(DEPTH);
    assign q_head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/core/fccw_back.sv -----
// Back end: FAT store, chain state, offset arithmetic and result register.
module fccw_back #(
    parameter int FAT_BYTES = fccw_pkg::FAT_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  fccw_pkg::q_entry_t              q_head,
    output logic                            pop,
    input  fccw_pkg::geo_t                  geo,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fccw_pkg::STATUS_W-1:0]   status,
    output logic [31:0]                     byte_offset,
    output logic [31:0]                     byte_count,
    output logic [fccw_pkg::CLUSTER_W-1:0]  cluster,
    output logic                            last
);

    localparam int AW = $clog2(FAT_BYTES);
    localparam int EW = fccw_pkg::ENTRY_ADDR_W;

    fccw_pkg::back_state_t state_reg, state_next;

    logic [7:0] fat_mem [FAT_BYTES];

    logic                            walking_reg;
    logic [fccw_pkg::CLUSTER_W-1:0]  chain_reg;
    logic [31:0]                     done_reg;
    logic [31:0]                     goal_reg;

    logic [31:0] t_reg, cnt_reg, off_reg;
    logic [fccw_pkg::CLUSTER_W-1:0] nxt_reg;
    logic        fin_reg;
    logic [7:0]  rd0_reg, rd1_reg;
    logic        ok0_reg, ok1_reg;

    logic                   out_valid_reg;
    fccw_pkg::status_t      status_reg;
    logic [31:0]            offset_reg, count_reg;
    logic [fccw_pkg::CLUSTER_W-1:0] cluster_reg;
    logic                   last_reg;

    logic out_free, warn_hit;
    logic do_write, do_start, do_reject, do_nofile, do_adv, do_emit, do_warn;

    logic [EW-1:0] at0, at1;
    logic [31:0]   remain, csize32, cnt_next, done_new;
    logic [39:0]   t_prod;
    logic [31:0]   base_sum;
    logic [47:0]   off_prod;
    logic [7:0]    b0, b1;
    logic [fccw_pkg::CLUSTER_W-1:0] nxt_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign warn_hit = !fin_reg && (nxt_reg >= fccw_pkg::END_MARK);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fccw_pkg::BK_IDLE:
            begin
                if (q_valid && (q_head.op == fccw_pkg::OP_ADVANCE) && walking_reg && geo.ready)
                begin
                    state_next = fccw_pkg::BK_ADV1;
                end
            end
            fccw_pkg::BK_ADV1: state_next = fccw_pkg::BK_ADV2;
            fccw_pkg::BK_ADV2: state_next = fccw_pkg::BK_EMIT;
            fccw_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = warn_hit ? fccw_pkg::BK_WARN : fccw_pkg::BK_IDLE;
                end
            end
            fccw_pkg::BK_WARN:
            begin
                if (out_free)
                begin
                    state_next = fccw_pkg::BK_IDLE;
                end
            end
            default: state_next = fccw_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        do_write  = 1'b0;
        do_start  = 1'b0;
        do_reject = 1'b0;
        do_nofile = 1'b0;
        do_adv    = 1'b0;
        do_emit   = 1'b0;
        do_warn   = 1'b0;
        unique case (state_reg)
            fccw_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_head.op)
                        fccw_pkg::OP_FAT_WRITE: do_write  = 1'b1;
                        fccw_pkg::OP_START:     do_start  = out_free;
                        fccw_pkg::OP_REJECT:    do_reject = out_free;
                        fccw_pkg::OP_ADVANCE:
                        begin
                            do_nofile = !walking_reg && out_free;
                            do_adv    = walking_reg && geo.ready;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            fccw_pkg::BK_EMIT: do_emit = out_free;
            fccw_pkg::BK_WARN: do_warn = out_free;
            default:
            begin
            end
        endcase
    end

    assign pop = do_write || do_start || do_reject || do_nofile || do_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fccw_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // FAT entry of cluster c sits at byte c + c/2
    assign at0 = EW'(chain_reg) + EW'(chain_reg >> 1);
    assign at1 = at0 + 1'b1;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            fat_mem[q_head.fat_addr[AW-1:0]] <= q_head.fat_byte;
        end
        rd0_reg <= fat_mem[at0[AW-1:0]];
        rd1_reg <= fat_mem[at1[AW-1:0]];
        ok0_reg <= 32'(at0) < 32'(FAT_BYTES);
        ok1_reg <= 32'(at1) < 32'(FAT_BYTES);
    end

    assign remain   = goal_reg - done_reg;
    assign csize32  = 32'(geo.csize);
    assign cnt_next = (remain < csize32) ? remain : csize32;
    assign t_prod   = 40'(32'(chain_reg) - fccw_pkg::FIRST_DATA_CLUSTER)
                    * 40'(geo.cluster_sectors);
    assign base_sum = geo.data_start + t_reg;
    assign off_prod = 48'(base_sum) * 48'(geo.sector_bytes);
    assign done_new = done_reg + cnt_reg;

    assign b0 = ok0_reg ? rd0_reg : 8'd0;
    assign b1 = ok1_reg ? rd1_reg : 8'd0;
    assign nxt_next = chain_reg[0] ? {b1, b0[7:4]} : {b1[3:0], b0};

    always_ff @(posedge clk)
    begin
        if (state_reg == fccw_pkg::BK_ADV1)
        begin
            t_reg   <= t_prod[31:0];
            cnt_reg <= cnt_next;
        end
        if (state_reg == fccw_pkg::BK_ADV2)
        begin
            off_reg <= off_prod[31:0];
            nxt_reg <= nxt_next;
            fin_reg <= done_new >= goal_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg <= 1'b0;
            chain_reg   <= '0;
            done_reg    <= '0;
            goal_reg    <= '0;
        end
        else
        begin
            if (do_start)
            begin
                chain_reg   <= q_head.start_cluster;
                done_reg    <= '0;
                goal_reg    <= q_head.file_size;
                walking_reg <= q_head.file_size != '0;
            end
            if (do_reject)
            begin
                walking_reg <= 1'b0;
            end
            if (do_emit)
            begin
                done_reg <= done_new;
                if (fin_reg || warn_hit)
                begin
                    walking_reg <= 1'b0;
                end
                else
                begin
                    chain_reg <= nxt_reg;
                end
            end
            if (do_warn)
            begin
                done_reg <= goal_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_start || do_reject || do_nofile || do_emit || do_warn)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_start || do_reject)
        begin
            status_reg  <= do_reject ? fccw_pkg::ST_TOO_LARGE : fccw_pkg::ST_ACCEPTED;
            offset_reg  <= '0;
            count_reg   <= q_head.file_size;
            cluster_reg <= q_head.start_cluster;
            last_reg    <= do_reject || (q_head.file_size == '0);
        end
        else if (do_nofile)
        begin
            status_reg  <= fccw_pkg::ST_NO_FILE;
            offset_reg  <= '0;
            count_reg   <= '0;
            cluster_reg <= '0;
            last_reg    <= 1'b1;
        end
        else if (do_emit)
        begin
            status_reg  <= fccw_pkg::ST_CHUNK;
            offset_reg  <= off_reg;
            count_reg   <= cnt_reg;
            cluster_reg <= chain_reg;
            last_reg    <= fin_reg;
        end
        else if (do_warn)
        begin
            status_reg  <= fccw_pkg::ST_ENDED_EARLY;
            offset_reg  <= off_reg;
            count_reg   <= goal_reg - done_reg;
            cluster_reg <= chain_reg;
            last_reg    <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign byte_offset = offset_reg;
    assign byte_count  = count_reg;
    assign cluster     = cluster_reg;
    assign last        = last_reg;

endmodule

// ----- rtl/core/fat12_cluster_chain_walker.sv -----
// Top level of the FAT12 cluster chain walker.
//
//  channel   handshake               payload
//  input     in_valid / in_stall     kind, fat_addr, fat_byte, start_cluster, file_size
//  output    out_valid / out_stall   status, byte_offset, byte_count, cluster, last
//  config    cfg_wr_en               cfg_index, cfg_data
//
// Advance: back-end states ADV1 ((c-2)*cluster_sectors), ADV2 (*sector_bytes, next FAT link) and EMIT,
// plus the WARN state when an early end marker adds a warning result.
// FAT write, start and no-file requests are handled in the back end's idle state.
// After reset and after each config write the geometry divider recomputes the data start;
// advances wait for it. FAT contents are undefined until written.
// A request queue and the output register let each side stall independently.
module fat12_cluster_chain_walker #(
    parameter int FAT_BYTES   = fccw_pkg::FAT_BYTES_DEF,
    parameter int QUEUE_DEPTH = fccw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       kind,
    input  logic [fccw_pkg::FAT_ADDR_W-1:0]  fat_addr,
    input  logic [7:0]                       fat_byte,
    input  logic [fccw_pkg::CLUSTER_W-1:0]   start_cluster,
    input  logic [fccw_pkg::SIZE_W-1:0]      file_size,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fccw_pkg::STATUS_W-1:0]    status,
    output logic [31:0]                      byte_offset,
    output logic [31:0]                      byte_count,
    output logic [fccw_pkg::CLUSTER_W-1:0]   cluster,
    output logic                             last,
    input  logic                             cfg_wr_en,
    input  logic [fccw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fccw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    fccw_pkg::geo_t     geo;
    fccw_pkg::q_entry_t push_entry, q_head;
    logic push, pop, q_valid, q_full;

    fccw_geometry u_geometry (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geo       (geo)
    );

    fccw_front #(
        .FAT_BYTES (FAT_BYTES)
    ) u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .fat_addr       (fat_addr),
        .fat_byte       (fat_byte),
        .start_cluster  (start_cluster),
        .file_size      (file_size),
        .max_file_bytes (geo.max_file_bytes),
        .q_full         (q_full),
        .push           (push),
        .push_entry     (push_entry)
    );

    fccw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_full     (q_full)
    );

    fccw_back #(
        .FAT_BYTES (FAT_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .pop         (pop),
        .geo         (geo),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .byte_offset (byte_offset),
        .byte_count  (byte_count),
        .cluster     (cluster),
        .last        (last)
    );

endmodule

// ----- dv/fat12_cluster_chain_walker_checker.sv -----
`timescale 1ns / 1ps
// Checker for the FAT12 cluster chain walker: mirrors the walk, predicts each report, compares.
module fat12_cluster_chain_walker_checker
    import fccw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [FAT_ADDR_W-1:0] fat_addr,
    input  logic [7:0]            fat_byte,
    input  logic [CLUSTER_W-1:0]  start_cluster,
    input  logic [SIZE_W-1:0]     file_size,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [STATUS_W-1:0]   status,
    input  logic [31:0]           byte_offset,
    input  logic [31:0]           byte_count,
    input  logic [CLUSTER_W-1:0]  cluster,
    input  logic                  last,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        status_t              st;
        logic [31:0]          off;
        logic [31:0]          cnt;
        logic [CLUSTER_W-1:0] cl;
        logic                 fin;
    } chunk_report_t;

    chunk_report_t chunk_reports[$];
    chunk_report_t got;

    logic [7:0]           fat_mem [FAT_BYTES_DEF];
    logic [CLUSTER_W-1:0] cur_cluster;
    logic [31:0]          done_bytes;
    logic [31:0]          goal_bytes;
    logic                 active;

    logic [15:0] sec_bytes;
    logic [7:0]  clus_secs;
    logic [15:0] rsvd_secs;
    logic [7:0]  copies;
    logic [15:0] fat_secs;
    logic [15:0] root_ents;
    logic [31:0] max_bytes;

    logic [31:0]          off;
    logic [31:0]          csize;
    logic [31:0]          remain;
    logic [31:0]          cnt;
    logic [CLUSTER_W-1:0] nxt;
    int                   miss;

    function automatic logic [31:0] cluster_base(input logic [CLUSTER_W-1:0] c);
        logic [31:0] root_secs;
        logic [31:0] start_sec;
        root_secs = 32'd0;
        if (sec_bytes != 16'd0)
            root_secs = (32'(root_ents) * 32'(DIR_ENTRY_BYTES) + 32'(sec_bytes) - 32'd1)
                        / 32'(sec_bytes);
        start_sec = 32'(rsvd_secs) + 32'(copies) * 32'(fat_secs) + root_secs;
        start_sec = start_sec + (32'(c) - FIRST_DATA_CLUSTER) * 32'(clus_secs);
        return start_sec * 32'(sec_bytes);
    endfunction

    function automatic logic [CLUSTER_W-1:0] next_link(input logic [CLUSTER_W-1:0] c);
        int         at;
        logic [7:0] b0;
        logic [7:0] b1;
        at = int'(c) + int'(c >> 1);
        b0 = fat_mem[at];
        b1 = fat_mem[at + 1];
        if (c[0])
            return {b1, b0[7:4]};
        return {b1[3:0], b0};
    endfunction

    function automatic void post_report(input status_t st, input logic [31:0] o,
                                        input logic [31:0] n, input logic [CLUSTER_W-1:0] c,
                                        input logic f);
        chunk_report_t r;
        r.st  = st;
        r.off = o;
        r.cnt = n;
        r.cl  = c;
        r.fin = f;
        chunk_reports.push_back(r);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            chunk_reports.delete();
            cur_cluster = '0;
            done_bytes  = '0;
            goal_bytes  = '0;
            active      = 1'b0;
            sec_bytes   = RST_SECTOR_BYTES;
            clus_secs   = RST_CLUSTER_SECTORS;
            rsvd_secs   = RST_RESERVED_COUNT;
            copies      = RST_FAT_COPIES;
            fat_secs    = RST_FAT_SECTORS;
            root_ents   = RST_ROOT_ENTRIES;
            max_bytes   = RST_MAX_FILE_BYTES;
            miss        = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SECTOR_BYTES:    sec_bytes = cfg_data[15:0];
                    REG_CLUSTER_SECTORS: clus_secs = cfg_data[7:0];
                    REG_RESERVED_COUNT:  rsvd_secs = cfg_data[15:0];
                    REG_FAT_COPIES:      copies    = cfg_data[7:0];
                    REG_FAT_SECTORS:     fat_secs  = cfg_data[15:0];
                    REG_ROOT_ENTRIES:    root_ents = cfg_data[15:0];
                    REG_MAX_FILE_BYTES:  max_bytes = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall) begin
                if (chunk_reports.size() == 0) begin
                    $error("report with none awaited: status %0d cluster %0d", status, cluster);
                    miss++;
                end
                else begin
                    got = chunk_reports.pop_front();
                    if (status !== got.st) begin
                        $error("status: expected %0d, got %0d", got.st, status);
                        miss++;
                    end
                    if (byte_offset !== got.off) begin
                        $error("byte_offset: expected %0h, got %0h", got.off, byte_offset);
                        miss++;
                    end
                    if (byte_count !== got.cnt) begin
                        $error("byte_count: expected %0h, got %0h", got.cnt, byte_count);
                        miss++;
                    end
                    if (cluster !== got.cl) begin
                        $error("cluster: expected %0h, got %0h", got.cl, cluster);
                        miss++;
                    end
                    if (last !== got.fin) begin
                        $error("last: expected %0b, got %0b", got.fin, last);
                        miss++;
                    end
                end
            end

            if (in_valid && !in_stall) begin
                case (kind)
                    KIND_FAT_WRITE: fat_mem[fat_addr] = fat_byte;
                    KIND_START: begin
                        if (file_size > max_bytes) begin
                            active = 1'b0;
                            post_report(ST_TOO_LARGE, 32'd0, file_size, start_cluster, 1'b1);
                        end
                        else begin
                            cur_cluster = start_cluster;
                            done_bytes  = 32'd0;
                            goal_bytes  = file_size;
                            active      = (file_size != 32'd0);
                            post_report(ST_ACCEPTED, 32'd0, file_size, start_cluster,
                                        file_size == 32'd0);
                        end
                    end
                    KIND_ADVANCE: begin
                        if (!active)
                            post_report(ST_NO_FILE, 32'd0, 32'd0, '0, 1'b1);
                        else begin
                            off        = cluster_base(cur_cluster);
                            csize      = 32'(clus_secs) * 32'(sec_bytes);
                            remain     = goal_bytes - done_bytes;
                            cnt        = (remain < csize) ? remain : csize;
                            done_bytes = done_bytes + cnt;
                            if (done_bytes >= goal_bytes) begin
                                active = 1'b0;
                                post_report(ST_CHUNK, off, cnt, cur_cluster, 1'b1);
                            end
                            else begin
                                post_report(ST_CHUNK, off, cnt, cur_cluster, 1'b0);
                                nxt = next_link(cur_cluster);
                                if (nxt >= END_MARK) begin
                                    post_report(ST_ENDED_EARLY, off, goal_bytes - done_bytes,
                                                cur_cluster, 1'b1);
                                    done_bytes = goal_bytes;
                                    active     = 1'b0;
                                end
                                else
                                    cur_cluster = nxt;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            fail_count <= miss;
            pending    <= chunk_reports.size();
        end
    end

endmodule

// ----- dv/fat12_cluster_chain_walker_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the FAT12 cluster chain walker: stimulus, idling and verdict.
module fat12_cluster_chain_walker_tb;
    import fccw_pkg::*;

    localparam int         ITEMS         = 1450;
    localparam int         PHASE_ITEMS   = 180;
    localparam int         SETTLE_CYCLES = 16;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            kind;
    logic [FAT_ADDR_W-1:0] fat_addr;
    logic [7:0]            fat_byte;
    logic [CLUSTER_W-1:0]  start_cluster;
    logic [SIZE_W-1:0]     file_size;
    logic                  out_valid;
    logic                  out_stall;
    logic [STATUS_W-1:0]   status;
    logic [31:0]           byte_offset;
    logic [31:0]           byte_count;
    logic [CLUSTER_W-1:0]  cluster;
    logic                  last;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int walk_pending;
    int walk_faults;

    logic [7:0]      fat_shadow [FAT_BYTES_DEF];
    int              burst_left;
    int              sent;
    bit              walk_live;
    longint unsigned plan_csize;
    logic [31:0]     plan_max;

    fat12_cluster_chain_walker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .fat_addr      (fat_addr),
        .fat_byte      (fat_byte),
        .start_cluster (start_cluster),
        .file_size     (file_size),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .byte_offset   (byte_offset),
        .byte_count    (byte_count),
        .cluster       (cluster),
        .last          (last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    fat12_cluster_chain_walker_checker chain_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .fat_addr      (fat_addr),
        .fat_byte      (fat_byte),
        .start_cluster (start_cluster),
        .file_size     (file_size),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .byte_offset   (byte_offset),
        .byte_count    (byte_count),
        .cluster       (cluster),
        .last          (last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (walk_faults),
        .pending       (walk_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: long hold first so the request queue fills, then random stall patterns
    initial
    begin
        int hold_cycles;
        int mode_len;
        int stall_pct;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        repeat ($urandom_range(5, 20)) @(posedge clk);
        hold_cycles = 400;
        forever
        begin
            repeat (hold_cycles)
            begin
                out_stall <= 1'b1;
                @(posedge clk);
            end
            mode_len = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat (mode_len)
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
                @(posedge clk);
            end
            hold_cycles = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : 0;
        end
    end

    task automatic send_req(input logic [1:0] k, input logic [FAT_ADDR_W-1:0] a,
                            input logic [7:0] b, input logic [CLUSTER_W-1:0] sc,
                            input logic [SIZE_W-1:0] fs);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        kind          <= k;
        fat_addr      <= a;
        fat_byte      <= b;
        start_cluster <= sc;
        file_size     <= fs;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (k != KIND_RESERVED)
            sent++;
    endtask

    task automatic fat_wr(input logic [FAT_ADDR_W-1:0] a, input logic [7:0] b);
        fat_shadow[a] = b;
        send_req(KIND_FAT_WRITE, a, b, 12'($urandom), $urandom);
    endtask

    task automatic start_file(input logic [CLUSTER_W-1:0] sc, input logic [SIZE_W-1:0] fs);
        send_req(KIND_START, 13'($urandom), 8'($urandom), sc, fs);
    endtask

    task automatic advance_walk();
        send_req(KIND_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom), $urandom);
    endtask

    // writes the packed 12-bit entry of cluster c, keeping the neighbor's nibble
    task automatic set_link(input logic [CLUSTER_W-1:0] c, input logic [CLUSTER_W-1:0] v);
        int at;
        at = int'(c) + int'(c >> 1);
        if (c[0])
        begin
            fat_shadow[at][7:4] = v[3:0];
            fat_shadow[at + 1]  = v[11:4];
        end
        else
        begin
            fat_shadow[at]        = v[7:0];
            fat_shadow[at + 1][3:0] = v[11:8];
        end
        fat_wr(13'(at), fat_shadow[at]);
        fat_wr(13'(at + 1), fat_shadow[at + 1]);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (walk_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_geometry(input int ph);
        logic [31:0] sb;
        logic [31:0] cs;
        logic [31:0] rc;
        logic [31:0] fc;
        logic [31:0] fsec;
        logic [31:0] re;
        logic [31:0] mx;
        case (ph)
            0: begin
                sb = 65535; cs = 255; rc = 65535; fc = 255; fsec = 65535; re = 65535;
                mx = 32'hFFFF_FFFF;
            end
            1: begin
                sb = 0; cs = 0; rc = 0; fc = 0; fsec = 0; re = 0;
                mx = $urandom_range(1000, 1 << 20);
            end
            2: begin
                sb = 1; cs = 0; rc = 7; fc = 1; fsec = 3; re = 16; mx = 200000;
            end
            3: begin
                sb = 1; cs = 1; rc = 0; fc = 0; fsec = 0; re = 0; mx = 0;
            end
            4: begin
                sb = 512; cs = 4; rc = 1; fc = 2; fsec = 9; re = 224; mx = 1474560;
            end
            default: begin
                sb   = ($urandom_range(0, 3) == 0) ? 512 : $urandom_range(1, 65535);
                cs   = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(0, 255);
                rc   = $urandom_range(0, 65535);
                fc   = $urandom_range(0, 255);
                fsec = $urandom_range(0, 65535);
                re   = $urandom_range(0, 65535);
                case ($urandom_range(0, 2))
                    0: mx = $urandom;
                    1: mx = $urandom_range(0, 200000);
                    default: mx = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        write_reg(REG_SECTOR_BYTES, sb);
        write_reg(REG_CLUSTER_SECTORS, cs);
        write_reg(REG_RESERVED_COUNT, rc);
        write_reg(REG_FAT_COPIES, fc);
        write_reg(REG_FAT_SECTORS, fsec);
        write_reg(REG_ROOT_ENTRIES, re);
        write_reg(REG_MAX_FILE_BYTES, mx);
        cfg_wr_en <= 1'b0;
        plan_csize = longint'(sb) * longint'(cs);
        plan_max   = mx;
    endtask

    // one file: optional noise, fresh chain entries, start, then the advances it needs (sometimes fewer or more)
    task automatic run_chain();
        logic [CLUSTER_W-1:0] chain [5];
        logic [31:0]          fs;
        longint unsigned      span;
        longint unsigned      top_sz;
        longint unsigned      q;
        int                   k;
        int                   n_need;
        int                   n_adv;
        int                   r;
        bit                   dup;
        if (!walk_live)
        begin
            repeat ($urandom_range(0, 3))
            begin
                case ($urandom_range(0, 3))
                    0, 1: fat_wr(13'($urandom), 8'($urandom));
                    2: advance_walk();
                    default: send_req(KIND_RESERVED, 13'($urandom), 8'($urandom),
                                      12'($urandom), $urandom);
                endcase
            end
        end

        k = $urandom_range(1, 5);
        case ($urandom_range(0, 7))
            0: chain[0] = 12'd0;
            1: chain[0] = 12'd1;
            2: chain[0] = 12'hFFF;
            3: chain[0] = 12'($urandom_range(END_MARK, 12'hFFF));
            default: chain[0] = 12'($urandom);
        endcase
        for (int i = 1; i < k; i++)
        begin
            do
            begin
                chain[i] = 12'($urandom_range(0, END_MARK - 1));
                dup = 1'b0;
                for (int j = 0; j < i; j++)
                    if (chain[j] == chain[i])
                        dup = 1'b1;
            end while (dup);
        end
        for (int i = 0; i < k; i++)
            set_link(chain[i], (i == k - 1) ? 12'($urandom_range(END_MARK, 12'hFFF))
                                            : chain[i + 1]);

        span = longint'(k) * plan_csize;
        case ($urandom_range(0, 9))
            0: fs = 32'd0;
            1: fs = plan_max;
            2: fs = plan_max + 32'd1;
            3: fs = $urandom;
            4, 5: fs = (span == 0 || span > 32'hFFFF_FFFF) ? $urandom_range(1, 5000)
                                                           : 32'(span);
            default: begin
                if (plan_csize == 0)
                    fs = $urandom_range(1, 5000);
                else
                begin
                    top_sz = span + plan_csize;
                    if (top_sz > 32'hFFFF_FFFF)
                        top_sz = 32'hFFFF_FFFF;
                    fs = $urandom_range(1, 32'(top_sz));
                end
            end
        endcase

        if (fs == 32'd0 || fs > plan_max)
            n_need = 0;
        else if (plan_csize == 0)
            n_need = k;
        else
        begin
            q = (longint'(fs) + plan_csize - 1) / plan_csize;
            n_need = (q > k) ? k : int'(q);
        end

        start_file(chain[0], fs);
        r = $urandom_range(0, 9);
        if (r == 0 && n_need > 0)
            n_adv = $urandom_range(0, n_need - 1);
        else if (r == 1)
            n_adv = n_need + $urandom_range(1, 2);
        else
            n_adv = n_need;
        repeat (n_adv) advance_walk();
        walk_live = (n_adv < n_need);
    endtask

    initial
    begin
        int ph;
        int phase_end;
        int tail;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        kind          <= KIND_FAT_WRITE;
        fat_addr      <= '0;
        fat_byte      <= '0;
        start_cluster <= '0;
        file_size     <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_SECTOR_BYTES;
        cfg_data      <= '0;
        burst_left = 0;
        sent       = 0;
        walk_live  = 1'b0;
        plan_csize = 512;
        plan_max   = RST_MAX_FILE_BYTES;
        for (int i = 0; i < FAT_BYTES_DEF; i++)
            fat_shadow[i] = 8'($urandom);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests on the reset geometry
        advance_walk();
        send_req(KIND_RESERVED, '1, '1, '1, '1);
        start_file(12'd0, 32'd0);
        start_file(12'hFFF, 32'd65537);
        start_file(12'h800, 32'hFFFF_FFFF);
        set_link(12'd2, 12'd3);
        set_link(12'd3, 12'hFFF);
        start_file(12'd2, 32'd1500);
        advance_walk();
        advance_walk();
        advance_walk();
        set_link(12'd0, 12'd1);
        set_link(12'd1, END_MARK);
        start_file(12'd0, 32'd1024);
        advance_walk();
        set_link(12'hFFF, 12'hFFF);
        start_file(12'hFFF, RST_MAX_FILE_BYTES);
        advance_walk();

        ph = 0;
        while (sent < ITEMS)
        begin
            settle();
            load_geometry(ph);
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end && sent < ITEMS)
                run_chain();
            ph++;
        end
        in_valid <= 1'b0;

        @(posedge clk);
        tail = 0;
        while (walk_pending != 0 && tail < 20000)
        begin
            @(posedge clk);
            tail++;
        end
        repeat (32) @(posedge clk);
        if (walk_faults == 0 && walk_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/fccw_pkg.sv
rtl/core/fccw_geometry.sv
rtl/core/fccw_front.sv
rtl/core/fccw_queue.sv
rtl/core/fccw_back.sv
rtl/core/fat12_cluster_chain_walker.sv
dv/fat12_cluster_chain_walker_checker.sv
dv/fat12_cluster_chain_walker_tb.sv
